>>> rtl/rmlos_pkg.sv
`default_nettype none

package rmlos_pkg;

    // output fixed point
    localparam int FRAC_BITS_DB = 8;

    // field and register widths
    localparam int D3_W       = 19;
    localparam int HRX_W      = 10;
    localparam int HTX_W      = 12;
    localparam int FREQ_W     = 15;
    localparam int GAIN_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TX_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CARRIER_MHZ = 2'd1;

    // register reset values
    localparam logic [HTX_W-1:0]  HTX_RESET  = 12'd560;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 15'd3500;

    // geometry widths
    localparam int D3SQ_W   = 2 * D3_W;
    localparam int DHSQ_W   = 2 * HTX_W;
    localparam int HH_W     = HTX_W + HRX_W;
    localparam int HHF_W    = HH_W + FREQ_W;
    localparam int KBP_W    = 23;
    localparam int KBP_SPLIT = 16;
    localparam int PLO_W    = KBP_SPLIT + KBP_W;
    localparam int PHI_W    = HHF_W - KBP_SPLIT + KBP_W;
    localparam int BPSUM_W  = HHF_W + KBP_W + 1;
    localparam int BP_W     = 28;
    localparam int BPSQ_W   = 2 * BP_W;
    localparam int XF_W     = BP_W + FREQ_W;

    // geometry constants
    localparam logic [KBP_W-1:0]   KBP_Q32   = 23'd5622099;
    localparam logic [BPSUM_W-1:0] BP_RND    = BPSUM_W'(64'd1 << 31);
    localparam logic [D3SQ_W-1:0]  MIN_D2_SQ = 38'd25600;
    localparam logic [D3SQ_W-1:0]  MAX_D2_SQ = 38'd112896000000;

    // log2 unit
    localparam int LOG_IN_W  = XF_W;
    localparam int LOG_N_W   = 6;
    localparam int LOG_F_W   = 24;
    localparam int LOG_W     = LOG_N_W + LOG_F_W;
    localparam int MANT_W    = 31;
    localparam int LOG_STEPS = LOG_F_W;
    localparam int LOG_LAT   = LOG_STEPS + 2;

    // loss terms
    localparam int C20_W  = 27;
    localparam int C40_W  = 28;
    localparam int CA_W   = 22;
    localparam int CLIN_W = 19;
    localparam int T20_W  = LOG_W + C20_W;
    localparam int T40_W  = LOG_W + C40_W;
    localparam int TA_W   = LOG_W + CA_W;
    localparam int LIN_W  = CLIN_W + BP_W;
    localparam int PL_W   = 50;
    localparam int TERM_SH = 16;

    localparam logic [C20_W-1:0]  C20_Q24  = 27'd101008905;
    localparam logic [C40_W-1:0]  C40_Q24  = 28'd202017810;
    localparam logic [CA_W-1:0]   CA_Q24   = 22'd2413678;
    localparam logic [CLIN_W-1:0] CLIN_Q32 = 19'd375257;
    localparam logic signed [PL_W-1:0] K0_Q32 = -50'sd227276928287;

    // rounding and saturation of the loss
    localparam int LOSS_W  = 16;
    localparam int LOSS_SH = 32 - FRAC_BITS_DB;
    localparam logic signed [PL_W-1:0] LOSS_RND = PL_W'(1) << (31 - FRAC_BITS_DB);
    localparam logic [LOSS_W-1:0] LOSS_MAX = 16'hFFFF;

    // front end to log and back end
    typedef struct packed {
        logic              valid;
        logic              oor;
        logic              near;
        logic [BP_W-1:0]   x;
        logic [D3_W-1:0]   d3;
        logic [XF_W-1:0]   xf;
    } t_front;

    // sideband that rides along the log units
    typedef struct packed {
        logic              valid;
        logic              oor;
        logic              near;
        logic [BP_W-1:0]   x;
    } t_side;

    // finished result
    typedef struct packed {
        logic                     valid;
        logic                     oor;
        logic signed [GAIN_W-1:0] gain;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/rmlos_front.sv
`default_nettype none

module rmlos_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [rmlos_pkg::D3_W-1:0]    i_distance_3d,
    input  wire logic [rmlos_pkg::HRX_W-1:0]   i_rx_height,
    input  wire logic [rmlos_pkg::HTX_W-1:0]   i_tx_height,
    input  wire logic [rmlos_pkg::FREQ_W-1:0]  i_carrier_mhz,
    output rmlos_pkg::t_front                  o_front
);
    import rmlos_pkg::*;

    // valid bits of the seven stages
    logic [6:0] r_vld;

    // stage 1: squares and height product
    logic [HTX_W-1:0]  n1_hr;
    logic [HTX_W-1:0]  n1_dh;
    logic [D3_W-1:0]   r1_d3;
    logic [D3SQ_W-1:0] r1_d3sq;
    logic [DHSQ_W-1:0] r1_dhsq;
    logic [HH_W-1:0]   r1_hh;

    // stage 2: squared 2D distance and range check
    logic [D3SQ_W-1:0] n2_d2sq;
    logic              n2_oor;
    logic [D3_W-1:0]   r2_d3;
    logic [D3SQ_W-1:0] r2_d2sq;
    logic              r2_oor;
    logic [HHF_W-1:0]  r2_hhf;

    // stage 3: breakpoint partial products
    logic [D3_W-1:0]   r3_d3;
    logic [D3SQ_W-1:0] r3_d2sq;
    logic              r3_oor;
    logic [PLO_W-1:0]  r3_plo;
    logic [PHI_W-1:0]  r3_phi;

    // stage 4: breakpoint
    logic [BPSUM_W-1:0] n4_sum;
    logic [BP_W-1:0]    n4_bp;
    logic [D3_W-1:0]    r4_d3;
    logic [D3SQ_W-1:0]  r4_d2sq;
    logic               r4_oor;
    logic [BP_W-1:0]    r4_bp;

    // stage 5: breakpoint squared
    logic [D3_W-1:0]    r5_d3;
    logic [D3SQ_W-1:0]  r5_d2sq;
    logic               r5_oor;
    logic [BP_W-1:0]    r5_bp;
    logic [BPSQ_W-1:0]  r5_bpsq;

    // stage 6: region select
    logic               n6_near;
    logic [D3_W-1:0]    r6_d3;
    logic               r6_oor;
    logic               r6_near;
    logic [BP_W-1:0]    r6_x;

    // stage 7: distance times carrier
    logic [D3_W-1:0]    r7_d3;
    logic               r7_oor;
    logic               r7_near;
    logic [BP_W-1:0]    r7_x;
    logic [XF_W-1:0]    r7_xf;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    // height difference
    always_comb begin
        n1_hr = HTX_W'(i_rx_height);
        n1_dh = (i_tx_height >= n1_hr) ? i_tx_height - n1_hr : n1_hr - i_tx_height;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d3   <= i_distance_3d;
            r1_d3sq <= D3SQ_W'(i_distance_3d) * D3SQ_W'(i_distance_3d);
            r1_dhsq <= DHSQ_W'(n1_dh) * DHSQ_W'(n1_dh);
            r1_hh   <= HH_W'(i_tx_height) * HH_W'(i_rx_height);
        end
    end

    // range check on the squared 2D distance
    always_comb begin
        n2_d2sq = r1_d3sq - D3SQ_W'(r1_dhsq);
        n2_oor  = (r1_d3sq < D3SQ_W'(r1_dhsq)) || (n2_d2sq < MIN_D2_SQ) ||
                  (n2_d2sq > MAX_D2_SQ);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_d3   <= r1_d3;
            r2_d2sq <= n2_d2sq;
            r2_oor  <= n2_oor;
            r2_hhf  <= HHF_W'(r1_hh) * HHF_W'(i_carrier_mhz);
        end
    end

    // height product times carrier times pi/2400, split in two halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_d3   <= r2_d3;
            r3_d2sq <= r2_d2sq;
            r3_oor  <= r2_oor;
            r3_plo  <= PLO_W'(r2_hhf[KBP_SPLIT-1:0]) * PLO_W'(KBP_Q32);
            r3_phi  <= PHI_W'(r2_hhf[HHF_W-1:KBP_SPLIT]) * PHI_W'(KBP_Q32);
        end
    end

    // recombine, round and clamp a zero breakpoint to one
    always_comb begin
        n4_sum = (BPSUM_W'(r3_phi) << KBP_SPLIT) + BPSUM_W'(r3_plo) + BP_RND;
        n4_bp  = n4_sum[32 +: BP_W];
        if (n4_bp == '0) begin
            n4_bp = BP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_d3   <= r3_d3;
            r4_d2sq <= r3_d2sq;
            r4_oor  <= r3_oor;
            r4_bp   <= n4_bp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_d3   <= r4_d3;
            r5_d2sq <= r4_d2sq;
            r5_oor  <= r4_oor;
            r5_bp   <= r4_bp;
            r5_bpsq <= BPSQ_W'(r4_bp) * BPSQ_W'(r4_bp);
        end
    end

    // a 2D distance at the breakpoint still counts as near
    assign n6_near = BPSQ_W'(r5_d2sq) <= r5_bpsq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_d3   <= r5_d3;
            r6_oor  <= r5_oor;
            r6_near <= n6_near;
            r6_x    <= n6_near ? BP_W'(r5_d3) : r5_bp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_d3   <= r6_d3;
            r7_oor  <= r6_oor;
            r7_near <= r6_near;
            r7_x    <= r6_x;
            r7_xf   <= XF_W'(r6_x) * XF_W'(i_carrier_mhz);
        end
    end

    assign o_front = '{valid: r_vld[6], oor: r7_oor, near: r7_near,
                       x: r7_x, d3: r7_d3, xf: r7_xf};

endmodule

`default_nettype wire

>>> rtl/rmlos_log2.sv
`default_nettype none

module rmlos_log2 (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [rmlos_pkg::LOG_IN_W-1:0] i_arg,
    output logic      [rmlos_pkg::LOG_W-1:0]    o_log
);
    import rmlos_pkg::*;

    // normalize: msb search, then shift
    logic [LOG_IN_W-1:0] n_arg;
    logic [LOG_N_W-1:0]  n_msb;
    logic [LOG_IN_W-1:0] r_arg;
    logic [LOG_N_W-1:0]  r_msb;

    // squaring pipeline
    logic [MANT_W-1:0]  r_mant [0:LOG_STEPS];
    logic [LOG_F_W-1:0] r_frac [0:LOG_STEPS];
    logic [LOG_N_W-1:0] r_int  [0:LOG_STEPS];

    // zero argument is taken as one
    always_comb begin
        n_arg = (i_arg == '0) ? LOG_IN_W'(1) : i_arg;
        n_msb = '0;
        for (int i = 0; i < LOG_IN_W; i++) begin
            if (n_arg[i]) begin
                n_msb = LOG_N_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arg <= n_arg;
            r_msb <= n_msb;
        end
    end

    // mantissa in [1, 2) with 30 fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant[0] <= MANT_W'({r_arg, (MANT_W - 1)'(0)} >> r_msb);
            r_frac[0] <= '0;
            r_int[0]  <= r_msb;
        end
    end

    // one fraction bit per stage, msb first
    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_sq
        logic [2*MANT_W-1:0] n_sq;

        assign n_sq = (2*MANT_W)'(r_mant[k]) * (2*MANT_W)'(r_mant[k]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mant[k+1] <= n_sq[2*MANT_W-1] ? n_sq[2*MANT_W-1 -: MANT_W]
                                                : n_sq[2*MANT_W-2 -: MANT_W];
                r_frac[k+1] <= r_frac[k] |
                               (LOG_F_W'(n_sq[2*MANT_W-1]) << (LOG_STEPS - 1 - k));
                r_int[k+1]  <= r_int[k];
            end
        end
    end

    assign o_log = {r_int[LOG_STEPS], r_frac[LOG_STEPS]};

endmodule

`default_nettype wire

>>> rtl/rmlos_back.sv
`default_nettype none

module rmlos_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire rmlos_pkg::t_side            i_side,
    input  wire logic [rmlos_pkg::LOG_W-1:0] i_log_xf,
    input  wire logic [rmlos_pkg::LOG_W-1:0] i_log_x,
    input  wire logic [rmlos_pkg::LOG_W-1:0] i_log_d3,
    output rmlos_pkg::t_result               o_res
);
    import rmlos_pkg::*;

    logic [3:0] r_vld;

    // stage 1: term products
    logic              r1_oor;
    logic              r1_far;
    logic [T20_W-1:0]  r1_t20p;
    logic [TA_W-1:0]   r1_tap;
    logic [T40_W-1:0]  r1_t40dp;
    logic [T40_W-1:0]  r1_t40bp;
    logic [LIN_W-1:0]  r1_linp;

    // stage 2: partial sums
    logic                   r2_oor;
    logic signed [PL_W-1:0] r2_sa;
    logic signed [PL_W-1:0] r2_sb;
    logic signed [PL_W-1:0] r2_sc;

    // stage 3: loss in Q32 dB
    logic                   r3_oor;
    logic signed [PL_W-1:0] r3_pl;

    // stage 4: rounded, saturated, negated
    logic signed [PL_W-1:0]   n4_rnd;
    logic signed [PL_W-1:0]   n4_full;
    logic [LOSS_W-1:0]        n4_loss;
    logic signed [GAIN_W-1:0] n4_gain;
    logic                     r4_oor;
    logic signed [GAIN_W-1:0] r4_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_side.valid};
        end
    end

    // log terms and linear term; x is the 3D distance near, the breakpoint far
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_oor   <= i_side.oor;
            r1_far   <= !i_side.near;
            r1_t20p  <= T20_W'(i_log_xf) * T20_W'(C20_Q24);
            r1_tap   <= TA_W'(i_log_x) * TA_W'(CA_Q24);
            r1_t40dp <= T40_W'(i_log_d3) * T40_W'(C40_Q24);
            r1_t40bp <= T40_W'(i_log_x) * T40_W'(C40_Q24);
            r1_linp  <= LIN_W'(i_side.x) * LIN_W'(CLIN_Q32);
        end
    end

    // far region adds the 40 dB per decade slope from the breakpoint
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_oor <= r1_oor;
            r2_sa  <= $signed(PL_W'(r1_t20p >> TERM_SH)) + $signed(PL_W'(r1_tap >> TERM_SH));
            r2_sb  <= $signed(PL_W'(r1_linp)) + K0_Q32;
            r2_sc  <= r1_far ? $signed(PL_W'(r1_t40dp >> TERM_SH)) -
                               $signed(PL_W'(r1_t40bp >> TERM_SH))
                             : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_oor <= r2_oor;
            r3_pl  <= r2_sa + r2_sb + r2_sc;
        end
    end

    // round half up, clamp to the 16-bit loss range, negate
    always_comb begin
        n4_rnd  = r3_pl + LOSS_RND;
        n4_full = n4_rnd >>> LOSS_SH;
        if (r3_pl[PL_W-1] || (r3_pl == '0)) begin
            n4_loss = '0;
        end else if (n4_full > $signed(PL_W'(LOSS_MAX))) begin
            n4_loss = LOSS_MAX;
        end else begin
            n4_loss = n4_full[LOSS_W-1:0];
        end
        n4_gain = r3_oor ? '0 : $signed(GAIN_W'(0) - GAIN_W'(n4_loss));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_oor  <= r3_oor;
            r4_gain <= n4_gain;
        end
    end

    assign o_res = '{valid: r_vld[3], oor: r4_oor, gain: r4_gain};

endmodule

`default_nettype wire

>>> rtl/rural_macro_los_path_loss.sv
// pipeline: geometry stages, the 24 squaring stages of the three log2 units,
//   then summing stages and an output register
// throughput: one transaction per clock while the skid stage is empty; a two-deep
//   output register and skid stage holds results while the master side stalls
// reset: synchronous, active low; clears all valid bits, tx_height to 560 and
//   carrier_mhz to 3500; no clearing pass, tready is high once reset is released
`default_nettype none

module rural_macro_los_path_loss (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // distance_3d [18:0], rx_height [28:19], zero fill [31:29]
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [rmlos_pkg::S_TDATA_W-1:0] i_s_tdata,
    // path_gain_db [16:0], zero fill [23:17]
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [rmlos_pkg::M_TDATA_W-1:0] o_m_tdata,
    // out_of_range [0]
    output logic                                 o_m_tuser,
    // register writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rmlos_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rmlos_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rmlos_pkg::*;

    logic                 w_en;
    logic [HTX_W-1:0]     r_tx_height;
    logic [FREQ_W-1:0]    r_carrier_mhz;
    t_front               w_front;
    t_side                w_side_in;
    t_side                r_side [0:LOG_LAT-1];
    logic [LOG_W-1:0]     w_log_xf;
    logic [LOG_W-1:0]     w_log_x;
    logic [LOG_W-1:0]     w_log_d3;
    t_result              w_res;
    logic                 r_out_v;
    t_result              r_out;
    logic                 r_skid_v;
    t_result              r_skid;

    // configuration registers, unknown indexes dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_height   <= HTX_RESET;
            r_carrier_mhz <= FREQ_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_TX_HEIGHT) begin
                r_tx_height <= i_cfg_data[HTX_W-1:0];
            end else if (i_cfg_index == CFG_IDX_CARRIER_MHZ) begin
                r_carrier_mhz <= i_cfg_data[FREQ_W-1:0];
            end
        end
    end

    // whole pipeline advances while the skid stage is empty
    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    rmlos_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_s_tvalid),
        .i_distance_3d (i_s_tdata[D3_W-1:0]),
        .i_rx_height   (i_s_tdata[D3_W +: HRX_W]),
        .i_tx_height   (r_tx_height),
        .i_carrier_mhz (r_carrier_mhz),
        .o_front       (w_front)
    );

    rmlos_log2 u_log_xf (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_arg (w_front.xf),
        .o_log (w_log_xf)
    );

    rmlos_log2 u_log_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_arg (LOG_IN_W'(w_front.x)),
        .o_log (w_log_x)
    );

    rmlos_log2 u_log_d3 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_arg (LOG_IN_W'(w_front.d3)),
        .o_log (w_log_d3)
    );

    // sideband delay matched to the log units
    assign w_side_in = '{valid: w_front.valid, oor: w_front.oor,
                         near: w_front.near, x: w_front.x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LOG_LAT; i++) begin
                r_side[i].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_side[0] <= w_side_in;
            for (int i = 1; i < LOG_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    rmlos_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_side   (r_side[LOG_LAT-1]),
        .i_log_xf (w_log_xf),
        .i_log_x  (w_log_x),
        .i_log_d3 (w_log_d3),
        .o_res    (w_res)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_res.valid;
            end
        end else if (w_res.valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (!r_skid_v) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {{(M_TDATA_W - GAIN_W){1'b0}}, r_out.gain};
    assign o_m_tuser  = r_out.oor;

endmodule

`default_nettype wire

>>> verif/rural_macro_los_path_loss_tb.sv
module rural_macro_los_path_loss_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // widths and register indexes of the block
    localparam int D3_W      = rmlos_pkg::D3_W;
    localparam int HRX_W     = rmlos_pkg::HRX_W;
    localparam int HTX_W     = rmlos_pkg::HTX_W;
    localparam int FREQ_W    = rmlos_pkg::FREQ_W;
    localparam int GAIN_W    = rmlos_pkg::GAIN_W;
    localparam int IDX_W     = rmlos_pkg::CFG_IDX_W;
    localparam int DATA_W    = rmlos_pkg::CFG_DATA_W;
    localparam int S_W       = rmlos_pkg::S_TDATA_W;
    localparam int M_W       = rmlos_pkg::M_TDATA_W;
    localparam int FRAC_DB   = rmlos_pkg::FRAC_BITS_DB;
    localparam logic [IDX_W-1:0] IDX_TX_HEIGHT   = rmlos_pkg::CFG_IDX_TX_HEIGHT;
    localparam logic [IDX_W-1:0] IDX_CARRIER_MHZ = rmlos_pkg::CFG_IDX_CARRIER_MHZ;
    // indexes with no register behind them
    localparam logic [IDX_W-1:0] IDX_SPARE_LO    = 2'd2;
    localparam logic [IDX_W-1:0] IDX_SPARE_HI    = 2'd3;

    // path loss arithmetic, q24 log slopes and q32 db terms
    localparam logic [63:0] SLOPE20_Q24 = 64'd101008905;
    localparam logic [63:0] SLOPE40_Q24 = 64'd202017810;
    localparam logic [63:0] SLOPEA_Q24  = 64'd2413678;
    localparam longint      LIN_Q32     = 64'sd375257;
    localparam longint      OFFSET_Q32  = -64'sd227276928287;
    localparam logic [63:0] BP_K_Q32    = 64'd5622099;
    localparam logic [63:0] D2SQ_MIN    = 64'd25600;
    localparam logic [63:0] D2SQ_MAX    = 64'd112896000000;
    localparam logic [63:0] LOSS_CAP    = 64'd65535;
    localparam logic [HTX_W-1:0]  TX_HEIGHT_RST = 12'd560;
    localparam logic [FREQ_W-1:0] CARRIER_RST   = 15'd3500;

    // run shape
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int TAIL_ITEMS      = 150;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 250;
    localparam int TAIL_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 400000;

    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} link_op_kind_t;

    typedef struct packed {
        link_op_kind_t     kind;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic [D3_W-1:0]   d3;
        logic [HRX_W-1:0]  hr;
    } link_op_t;

    typedef struct packed {
        logic                     oor;
        logic signed [GAIN_W-1:0] gain;
    } path_result_t;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [S_W-1:0]    s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [M_W-1:0]    m_tdata;
    logic              m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data  = '0;

    link_op_t     link_queue[$];
    path_result_t expected_gain[$];

    // register copies seen by the predictor
    logic [HTX_W-1:0]  tx_height_now = TX_HEIGHT_RST;
    logic [FREQ_W-1:0] carrier_now   = CARRIER_RST;

    int total_items = 0;
    int n_settings  = 1;
    int n_sent      = 0;
    int n_recv      = 0;
    int n_oor       = 0;
    int n_writes    = 0;
    int n_errors    = 0;
    int n_cycles    = 0;
    int gap_cnt     = 0;
    int stall_cnt   = 0;
    int hold_cnt    = 0;
    bit hold_done   = 1'b0;

    rural_macro_los_path_loss dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // log2 in q24: msb index, then 24 truncating squarings of a q30 mantissa
    function automatic logic [63:0] log2_q24(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] m;
        logic [63:0] r;
        int          n;
        x = (x_in == 0) ? 64'd1 : x_in;
        n = 0;
        while (n < 63 && (x >> (n + 1)) != 0)
            n++;
        if (n >= 30)
            m = x >> (n - 30);
        else
            m = x << (30 - n);
        r = 64'(n) << 24;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    // slope times log2, q32 db
    function automatic longint log_db_q32(input logic [63:0] x, input logic [63:0] slope);
        logic [63:0] p;
        p = (log2_q24(x) * slope) >> 16;
        return longint'(p);
    endfunction

    // near region loss at distance x with carrier f, q32 db
    function automatic longint near_loss_q32(input logic [63:0] x, input logic [63:0] f);
        return log_db_q32(x * f, SLOPE20_Q24) + log_db_q32(x, SLOPEA_Q24)
             + LIN_Q32 * longint'(x) + OFFSET_Q32;
    endfunction

    // breakpoint distance in 1/16 m, never zero
    function automatic logic [63:0] breakpoint_q4(input logic [63:0] ht, input logic [63:0] hr,
                                                  input logic [63:0] f);
        logic [63:0] bp;
        bp = (ht * hr * f * BP_K_Q32 + (64'd1 << 31)) >> 32;
        return (bp == 0) ? 64'd1 : bp;
    endfunction

    // expected gain and range flag for one link under the current registers
    function automatic path_result_t predict_path_gain(input logic [D3_W-1:0] d3_in,
                                                       input logic [HRX_W-1:0] hr_in);
        logic [63:0]  d3;
        logic [63:0]  hr;
        logic [63:0]  ht;
        logic [63:0]  f;
        logic [63:0]  dh;
        logic [63:0]  d2sq;
        logic [63:0]  bp;
        logic [63:0]  loss;
        logic [63:0]  neg;
        longint       pl;
        path_result_t res;
        d3 = 64'(d3_in);
        hr = 64'(hr_in);
        ht = 64'(tx_height_now);
        f  = 64'(carrier_now);
        dh = (ht > hr) ? ht - hr : hr - ht;
        res.oor  = 1'b1;
        res.gain = '0;
        if (d3 * d3 < dh * dh)
            return res;
        d2sq = d3 * d3 - dh * dh;
        if (d2sq < D2SQ_MIN || d2sq > D2SQ_MAX)
            return res;
        bp = breakpoint_q4(ht, hr, f);
        // a 2d distance equal to the breakpoint stays in the near region
        if (d2sq <= bp * bp)
            pl = near_loss_q32(d3, f);
        else
            pl = near_loss_q32(bp, f) + log_db_q32(d3, SLOPE40_Q24)
               - log_db_q32(bp, SLOPE40_Q24);
        if (pl <= 0) begin
            loss = 64'd0;
        end else begin
            loss = ($unsigned(pl) + (64'd1 << (31 - FRAC_DB))) >> (32 - FRAC_DB);
            if (loss > LOSS_CAP)
                loss = LOSS_CAP;
        end
        neg = 64'd0 - loss;
        res.oor  = 1'b0;
        res.gain = neg[GAIN_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 n_recv, what, got, want);
        n_errors++;
    endtask

    // stimulus planning
    task automatic queue_item(input int unsigned d3, input int unsigned hr);
        link_op_t op;
        op      = '0;
        op.kind = OP_ITEM;
        op.d3   = d3[D3_W-1:0];
        op.hr   = hr[HRX_W-1:0];
        link_queue.push_back(op);
        total_items++;
    endtask

    task automatic queue_write(input logic [IDX_W-1:0] idx, input int unsigned value);
        link_op_t op;
        op      = '0;
        op.kind = OP_CFG;
        op.idx  = idx;
        op.data = value[DATA_W-1:0];
        link_queue.push_back(op);
    endtask

    // wait for the pipeline to empty, then load both registers
    task automatic queue_setting(input int unsigned tx, input int unsigned f);
        link_op_t op;
        op      = '0;
        op.kind = OP_DRAIN;
        link_queue.push_back(op);
        queue_write(IDX_TX_HEIGHT, tx);
        queue_write(IDX_CARRIER_MHZ, f);
        n_settings++;
    endtask

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", n_cycles,
                     expected_gain.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus plan, reset and end of run
    initial begin
        int unsigned tx;
        int unsigned f;
        int unsigned hr;
        int unsigned dh;
        int unsigned d3;
        logic [63:0] bp;
        link_op_t    op;

        // reset registers: range edges and the height difference case
        queue_item(0, 1);
        queue_item(524287, 1023);
        queue_item(581, 1);
        queue_item(582, 1);
        queue_item(336000, 560);
        queue_item(336001, 560);
        queue_item(1000, 1023);

        // tallest mast, highest carrier
        queue_setting(4095, 30000);
        queue_item(200000, 1023);
        queue_item(5000, 1);
        queue_item(524287, 1);

        // breakpoint inside the range, probed on both sides and on it
        queue_setting(512, 400);
        bp = breakpoint_q4(64'd512, 64'd512, 64'd400);
        queue_item(32'(bp - 64'd1), 512);
        queue_item(32'(bp), 512);
        queue_item(32'(bp + 64'd1), 512);

        // lowest legal setting: breakpoint below 10 m, far formula everywhere
        queue_setting(16, 400);
        queue_item(200, 1);
        queue_item(100000, 1);

        // zero height and carrier: unit breakpoint and log argument
        queue_setting(0, 0);
        queue_write(IDX_SPARE_LO, 32'h7FFF);
        queue_write(IDX_SPARE_HI, 32'h1234);
        queue_item(1000, 5);
        queue_item(300000, 1023);

        // tiny carrier: breakpoint under 1 m, far formula for every link
        queue_setting(100, 1);
        queue_item(160, 100);
        queue_item(170, 100);
        queue_item(2000, 50);

        // random settings with mostly well-formed links
        for (int p = 0; p < RAND_PHASES; p++) begin
            tx = $urandom_range(16, 4095);
            f  = $urandom_range(400, 30000);
            case ($urandom_range(0, 3))
                0: tx = ($urandom_range(0, 1) != 0) ? 16 : 4095;
                1: f  = ($urandom_range(0, 1) != 0) ? 400 : 30000;
                default: ;
            endcase
            if (p % 3 == 0)
                tx = $urandom_range(16, 1023);
            queue_setting(tx, f);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // sender pause until every result is back
                if (p == 6 && k == ITEMS_PER_PHASE / 2) begin
                    op      = '0;
                    op.kind = OP_DRAIN;
                    link_queue.push_back(op);
                end
                hr = $urandom_range(1, 1023);
                dh = (tx > hr) ? tx - hr : hr - tx;
                case ($urandom_range(0, 9))
                    0: d3 = $urandom_range(0, 524287);
                    1: d3 = dh + $urandom_range(0, 200);
                    2: d3 = $urandom_range(335980, 336040);
                    3: begin
                        if (tx <= 1023)
                            hr = tx;
                        bp = breakpoint_q4(64'(tx), 64'(hr), 64'(f));
                        if (bp < 64'd336100) begin
                            d3 = 32'(bp) + $urandom_range(0, 8);
                            d3 = (d3 > 4) ? d3 - 4 : 0;
                        end else begin
                            d3 = $urandom_range(160, 336000);
                        end
                    end
                    default: d3 = $urandom_range(160, 336000);
                endcase
                queue_item(d3, hr);
            end
        end

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < total_items)
            @(posedge i_clk);
        while (expected_gain.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d links over %0d register settings with %0d register writes",
                 n_sent, n_settings, n_writes);
        $display("checked %0d results, %0d of them out of range", n_recv, n_oor);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Some tests failed");
        end
        $finish;
    end

    // driver: link and register transactions from the plan
    always @(posedge i_clk) begin : drive_links
        logic           s_next;
        logic           cfg_next;
        logic           idle_ok;
        logic [S_W-1:0] word;
        link_op_t       op;
        path_result_t   res;
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            gap_cnt = 0;
        end else begin
            // predict each accepted link
            if (s_tvalid && s_tready) begin
                res = predict_path_gain(s_tdata[D3_W-1:0], s_tdata[D3_W+HRX_W-1:D3_W]);
                expected_gain.push_back(res);
                if (res.oor)
                    n_oor++;
                n_sent++;
            end
            // track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    IDX_TX_HEIGHT:   tx_height_now = cfg_data[HTX_W-1:0];
                    IDX_CARRIER_MHZ: carrier_now   = cfg_data[FREQ_W-1:0];
                    default: ;
                endcase
                n_writes++;
            end

            s_next   = s_tvalid && !s_tready;
            cfg_next = cfg_valid && !cfg_ready;
            idle_ok  = (n_sent + TAIL_ITEMS < total_items) && ((n_sent / 97) % 4 != 3);

            if (!s_next && !cfg_next && link_queue.size() != 0) begin
                op = link_queue[0];
                if (gap_cnt != 0) begin
                    gap_cnt--;
                end else begin
                    case (op.kind)
                        OP_DRAIN: begin
                            if (expected_gain.size() == 0)
                                op = link_queue.pop_front();
                        end
                        OP_CFG: begin
                            op = link_queue.pop_front();
                            cfg_next = 1'b1;
                            cfg_index <= op.idx;
                            cfg_data  <= op.data;
                        end
                        default: begin
                            if (idle_ok && $urandom_range(0, 3) == 0) begin
                                gap_cnt = $urandom_range(0, 14);
                            end else begin
                                op = link_queue.pop_front();
                                word = '0;
                                word[D3_W-1:0]           = op.d3;
                                word[D3_W+HRX_W-1:D3_W] = op.hr;
                                s_next = 1'b1;
                                s_tdata <= word;
                            end
                        end
                    endcase
                end
            end
            s_tvalid  <= s_next;
            cfg_valid <= cfg_next;
        end
    end

    // monitor: result transactions against the oldest expectation
    always @(posedge i_clk) begin : check_results
        path_result_t want;
        logic         ready_next;
        logic         idle_ok;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_cnt = 0;
            hold_cnt  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_recv++;
                if (expected_gain.size() == 0) begin
                    flag_mismatch("result with nothing expected, gain",
                                  longint'($signed(m_tdata[GAIN_W-1:0])), 64'sd0);
                end else begin
                    want = expected_gain.pop_front();
                    if (m_tdata[GAIN_W-1:0] !== want.gain)
                        flag_mismatch("path_gain_db", longint'($signed(m_tdata[GAIN_W-1:0])),
                                      longint'(want.gain));
                    if (m_tuser !== want.oor)
                        flag_mismatch("out_of_range", longint'(m_tuser), longint'(want.oor));
                    if (m_tdata[M_W-1:GAIN_W] !== '0)
                        flag_mismatch("tdata fill bits", longint'(m_tdata[M_W-1:GAIN_W]),
                                      64'sd0);
                end
            end

            idle_ok = (n_recv + TAIL_ITEMS < total_items) && ((n_recv / 89) % 4 != 2);
            if (hold_cnt != 0) begin
                hold_cnt--;
                ready_next = 1'b0;
            end else if (!hold_done && n_recv >= HOLD_AT) begin
                // long hold-off so the block backs up into its input
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES - 1;
                ready_next = 1'b0;
            end else if (stall_cnt != 0) begin
                stall_cnt--;
                ready_next = 1'b0;
            end else if (idle_ok && $urandom_range(0, 3) == 0) begin
                stall_cnt  = $urandom_range(0, 14);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

endmodule

>>> filelist.f
rtl/rmlos_pkg.sv
rtl/rmlos_front.sv
rtl/rmlos_log2.sv
rtl/rmlos_back.sv
rtl/rural_macro_los_path_loss.sv
verif/rural_macro_los_path_loss_tb.sv
